@@ sv/egspc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package egspc_pkg;

    localparam int TIME_W     = 48;
    localparam int DEBOUNCE_W = 20;
    localparam int LONG_W     = 24;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(20000);
    localparam logic [LONG_W-1:0]     LONG_RESET     = LONG_W'(600000);

    // register index = paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_SWAP     = 2'd2;

    localparam logic [1:0] PRESS_NONE  = 2'd0;
    localparam logic [1:0] PRESS_SHORT = 2'd1;
    localparam logic [1:0] PRESS_LONG  = 2'd2;

    // step for a move between pair codes (A*2+B), indexed by {from, to}
    localparam logic [1:0] GRAY_TABLE [16] = '{
        2'b00, 2'b01, 2'b11, 2'b00,
        2'b11, 2'b00, 2'b00, 2'b01,
        2'b01, 2'b00, 2'b00, 2'b11,
        2'b00, 2'b11, 2'b01, 2'b00
    };

    typedef struct packed {
        logic              chan_a;
        logic              chan_b;
        logic              ab_valid;
        logic              switch_level;
        logic              switch_valid;
        logic [TIME_W-1:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic signed [1:0] step;
        logic [1:0]        press_event;
    } out_item_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_time_us;
        logic [LONG_W-1:0]     long_press_time_us;
        logic                  swap_channels;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/egspc_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module egspc_regs
    import egspc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time_us   <= DEBOUNCE_RESET;
            cfg_reg.long_press_time_us <= LONG_RESET;
            cfg_reg.swap_channels      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: cfg_reg.debounce_time_us   <= pwdata[DEBOUNCE_W-1:0];
                REG_LONG:     cfg_reg.long_press_time_us <= pwdata[LONG_W-1:0];
                REG_SWAP:     cfg_reg.swap_channels      <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = DATA_W'(cfg_reg.debounce_time_us);
            REG_LONG:     prdata = DATA_W'(cfg_reg.long_press_time_us);
            REG_SWAP:     prdata = DATA_W'(cfg_reg.swap_channels);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/egspc_quad.sv @@
`timescale 1ns / 1ps
`default_nettype none

module egspc_quad
    import egspc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire logic  chan_a,
    input  wire logic  chan_b,
    input  wire logic  ab_valid,
    input  wire logic  swap,
    output logic signed [1:0] step
);

    logic [1:0] prev_ab_reg;
    logic [1:0] ab;

    assign ab   = swap ? {chan_b, chan_a} : {chan_a, chan_b};
    assign step = ab_valid ? $signed(GRAY_TABLE[{prev_ab_reg, ab}]) : 2'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg <= 2'b11;
        end
        else if (advance && ab_valid)
        begin
            prev_ab_reg <= ab;
        end
    end

endmodule

`default_nettype wire

@@ sv/egspc_press.sv @@
`timescale 1ns / 1ps
`default_nettype none

module egspc_press
    import egspc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              switch_valid,
    input  wire logic              switch_level,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire cfg_t              cfg,
    output logic [1:0]             press_event
);

    logic              stable_reg;
    logic [TIME_W-1:0] last_change_reg;
    logic              long_done_reg;

    logic [TIME_W-1:0] diff;
    logic              change;
    logic              long_fire;
    logic              update;

    // diff wraps modulo 2^TIME_W
    assign diff   = now_us - last_change_reg;
    assign change = (switch_level != stable_reg)
                    && (diff > TIME_W'(cfg.debounce_time_us));
    // an accepted change restarts the hold time at zero, so no long press then
    assign long_fire = !change && !stable_reg && !long_done_reg
                       && (diff > TIME_W'(cfg.long_press_time_us));
    assign update = advance && switch_valid;

    always_comb
    begin
        press_event = PRESS_NONE;
        if (switch_valid)
        begin
            if (change && switch_level && !long_done_reg)
            begin
                press_event = PRESS_SHORT;
            end
            else if (long_fire)
            begin
                press_event = PRESS_LONG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b1;
            last_change_reg <= '0;
            long_done_reg   <= 1'b0;
        end
        else if (update)
        begin
            if (change)
            begin
                stable_reg      <= switch_level;
                last_change_reg <= now_us;
                if (!switch_level)
                begin
                    long_done_reg <= 1'b0;
                end
            end
            if (long_fire)
            begin
                long_done_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/encoder_gray_step_and_press_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotary encoder sampler. Each input transfer is one sample of the A/B pins,
// the active-low switch and a microsecond timestamp; each sample gives exactly
// one output transfer with a Gray-code step (+1, -1 or 0) and a press event
// (none, short, long). A sample passes an input register, then combinational
// decode and debounce logic into the output register; one sample is taken
// every cycle as long as the output is drained. The 48-bit timestamp subtract
// and compare sets the critical path. Debounce time, long press time and A/B
// swap are set over the APB port at 0x0, 0x4, 0x8.
module encoder_gray_step_and_press_classifier
    import egspc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;

    logic              out_free;
    logic              advance;
    logic              in_take;
    logic signed [1:0] step;
    logic [1:0]        press_event;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    egspc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    egspc_quad u_quad (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .chan_a   (in_item_reg.chan_a),
        .chan_b   (in_item_reg.chan_b),
        .ab_valid (in_item_reg.ab_valid),
        .swap     (cfg.swap_channels),
        .step     (step)
    );

    egspc_press u_press (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .switch_valid (in_item_reg.switch_valid),
        .switch_level (in_item_reg.switch_level),
        .now_us       (in_item_reg.now_us),
        .cfg          (cfg),
        .press_event  (press_event)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg.step        <= step;
            out_item_reg.press_event <= press_event;
        end
    end

endmodule

`default_nettype wire

@@ sv/egspc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module egspc_checker
    import egspc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // a stalled output transfer holds its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // input backpressure only comes from a blocked output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.step != 2'b10)
        else $error("step out of range");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.press_event == PRESS_NONE
                       || out_data.press_event == PRESS_SHORT
                       || out_data.press_event == PRESS_LONG))
        else $error("bad press event code");

endmodule

bind encoder_gray_step_and_press_classifier egspc_checker u_egspc_checker (.*);

`default_nettype wire
